@@ sv/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the spectrum baseline comparator.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int MAG_W = 24;
   localparam int BW_W  = 16;
   localparam int RUN_W = 4;
   localparam int STATUS_W = 2;
   localparam int PEAK_OUT_W = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // status codes
   localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CAUTION = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_BIN_WIDTH = 2'd0;
   localparam logic [1:0] REG_MIN_PEAK  = 2'd1;
   localparam logic [1:0] REG_RUN_LEN   = 2'd2;

   // register reset values
   localparam logic [BW_W-1:0]  RST_BIN_WIDTH = 16'd2000;
   localparam logic [MAG_W-1:0] RST_MIN_PEAK  = 24'd20480;
   localparam logic [RUN_W-1:0] RST_RUN_LEN   = 4'd3;

   // Q8.8 Hz thresholds and Q16.8 band floor
   localparam logic [BW_W-1:0]  FREQ_GOOD_Q8    = 16'd1280;
   localparam logic [BW_W-1:0]  FREQ_CAUTION_Q8 = 16'd3072;
   localparam logic [MAG_W-1:0] BAND_FLOOR_Q8   = 24'd256;

   localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

   typedef struct packed {
      logic [BW_W-1:0]  bin_width;
      logic [MAG_W-1:0] min_base_peak;
      logic [RUN_W-1:0] run_length;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RUN_W-1:0]    run;
   } verdict_type;

endpackage

@@ sv/sbc_ram.sv @@
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sbc_csr.sv @@
// ----------------------------------------------------------------------------
// sbc_csr
// APB-style configuration registers: bin width, minimum baseline peak and
// error run length.
// ----------------------------------------------------------------------------
module sbc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sbc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sbc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sbc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output sbc_pkg::cfg_type               cfg
);
   import sbc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_stb;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_stb  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_BIN_WIDTH: cfg_in.bin_width     = pwdata[BW_W-1:0];
            REG_MIN_PEAK:  cfg_in.min_base_peak = pwdata[MAG_W-1:0];
            REG_RUN_LEN:   cfg_in.run_length    = pwdata[RUN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_width     <= RST_BIN_WIDTH;
         cfg_ff.min_base_peak <= RST_MIN_PEAK;
         cfg_ff.run_length    <= RST_RUN_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BIN_WIDTH: prdata = CSR_DATA_W'(cfg_ff.bin_width);
         REG_MIN_PEAK:  prdata = CSR_DATA_W'(cfg_ff.min_base_peak);
         REG_RUN_LEN:   prdata = CSR_DATA_W'(cfg_ff.run_length);
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

@@ sv/sbc_judge.sv @@
// ----------------------------------------------------------------------------
// sbc_judge
// Frame verdict: frequency distance, peak ratio and band ratio tests, weak
// baseline bypass and error run update.
// ----------------------------------------------------------------------------
module sbc_judge #(
   parameter int SUM_W  = 27,
   parameter int FREQ_W = 23
) (
   input  logic [sbc_pkg::MAG_W-1:0] base_peak,
   input  logic [sbc_pkg::MAG_W-1:0] live_peak,
   input  logic [SUM_W-1:0]          base_sum,
   input  logic [SUM_W-1:0]          live_sum,
   input  logic [FREQ_W-1:0]         freq,
   input  logic [sbc_pkg::RUN_W-1:0] run_in,
   input  sbc_pkg::cfg_type          cfg,
   output sbc_pkg::verdict_type      verdict
);
   import sbc_pkg::*;

   localparam int TW = SUM_W + 3;

   // max(a,b)/min(a,b) < num/2, by cross-multiplication
   function automatic logic ratio_below(input logic [SUM_W-1:0] a,
                                        input logic [SUM_W-1:0] b,
                                        input logic [2:0]       num);
      logic [SUM_W-1:0] hi;
      logic [SUM_W-1:0] lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return (TW'({hi, 1'b0}) < (TW'(lo) * TW'(num)));
   endfunction

   logic [SUM_W-1:0]    bsum, lsum, bpk, lpk, floor_v;
   logic                good, caution, weak_base;
   logic [STATUS_W-1:0] inst;
   logic [RUN_W-1:0]    run_nx, need;

   always_comb begin
      floor_v = SUM_W'(BAND_FLOOR_Q8);
      bsum = (base_sum < floor_v) ? floor_v : base_sum;
      lsum = (live_sum < floor_v) ? floor_v : live_sum;
      bpk  = SUM_W'(base_peak);
      lpk  = SUM_W'(live_peak);
      weak_base = base_peak < cfg.min_base_peak;

      good    = (freq < FREQ_W'(FREQ_GOOD_Q8)) && ratio_below(bpk, lpk, 3'd3) &&
                ratio_below(bsum, lsum, 3'd3);
      caution = (freq < FREQ_W'(FREQ_CAUTION_Q8)) && ratio_below(bpk, lpk, 3'd5) &&
                ratio_below(bsum, lsum, 3'd5);
      inst = good ? ST_GOOD : (caution ? ST_CAUTION : ST_ERROR);

      if (inst == ST_ERROR) begin
         run_nx = (run_in == RUN_MAX) ? RUN_MAX : run_in + 1'b1;
      end else begin
         run_nx = '0;
      end
      need = (cfg.run_length == '0) ? RUN_W'(1) : cfg.run_length;

      if (weak_base) begin
         verdict.status = ST_GOOD;
         verdict.run    = '0;
      end else begin
         verdict.status = (run_nx >= need) ? ST_ERROR : inst;
         verdict.run    = run_nx;
      end
   end

endmodule

@@ sv/spectrum_baseline_comparator_unit.sv @@
// ----------------------------------------------------------------------------
// spectrum_baseline_comparator_unit
// Compares a live magnitude spectrum against a stored baseline and returns a
// good / caution / error verdict once per frame.
// ----------------------------------------------------------------------------
// Bins are taken one word per cycle, bin 0 first, while the block collects a
// frame; baseline and live magnitudes go into two RAMs and the first strict
// peak of each spectrum (from bin 1) is tracked on the fly. The word marked
// last_bin closes the frame: the block then holds req_stall high, re-reads
// the band of up to 2*BAND_HALF_WIDTH+1 bins round the baseline peak through
// the single read port of each RAM, one bin a cycle, and judges the frame.
// After the last bin is accepted the block sets up the band bounds and the
// frequency distance, reads the clipped band (at most 7 bins with the default
// half width; skipped when the band is empty), judges the frame and loads the
// result word; it is held back only while the output register is stalled, and the
// next frame may start as soon as it is loaded into the output register. The RAMs
// need no clearing pass: the band never reaches past bins written in the
// current frame. Bins beyond BINS-1 are dropped, but a late last_bin still
// ends the frame. Registers: 0x0 bin width (Q8.8 Hz), 0x4 minimum baseline
// peak (Q16.8), 0x8 error run length (0 acts as 1).
// ----------------------------------------------------------------------------
module spectrum_baseline_comparator_unit #(
   parameter int BINS            = 128,
   parameter int BAND_HALF_WIDTH = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   // bin input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sbc_pkg::MAG_W-1:0]      req_base_mag,
   input  logic [sbc_pkg::MAG_W-1:0]      req_live_mag,
   input  logic                           req_last_bin,
   input  logic                           req_clear_run,
   // verdict output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sbc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sbc_pkg::PEAK_OUT_W-1:0] rsp_base_peak_bin,
   output logic [sbc_pkg::PEAK_OUT_W-1:0] rsp_live_peak_bin,
   output logic [sbc_pkg::RUN_W-1:0]      rsp_error_run,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sbc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sbc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sbc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sbc_pkg::*;

   localparam int AW     = $clog2(BINS);          // bin index / RAM address
   localparam int CNTW   = $clog2(BINS + 1);      // bin count, holds BINS
   localparam int CW     = CNTW + 6;              // band bound arithmetic
   localparam int SUM_W  = MAG_W + $clog2(2 * BAND_HALF_WIDTH + 2);
   localparam int FREQ_W = AW + BW_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_BAND  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   cfg_type     cfg;
   verdict_type verdict;

   logic [2:0] state_ff, state_in;

   // frame collection
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0] bpk_val_ff, bpk_val_in, lpk_val_ff, lpk_val_in;
   logic [AW-1:0]    bpk_idx_ff, bpk_idx_in, lpk_idx_ff, lpk_idx_in;

   // closed frame, held through the band pass
   logic [MAG_W-1:0] fb_val_ff, fb_val_in, fl_val_ff, fl_val_in;
   logic [AW-1:0]    fb_idx_ff, fb_idx_in, fl_idx_ff, fl_idx_in;
   logic [CNTW-1:0]  size_ff, size_in;

   // band pass
   logic [AW-1:0]     rd_addr_ff, rd_addr_in, band_end_ff, band_end_in;
   logic              rd_pend_ff, rd_pend_in, rd_en;
   logic [SUM_W-1:0]  bsum_ff, bsum_in, lsum_ff, lsum_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [CW-1:0]     pk_ext, band_lo, band_hi_raw, band_hi, size_ext;
   logic              band_empty;
   logic [AW-1:0]     peak_dist;

   logic [RUN_W-1:0] run_ff, run_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PEAK_OUT_W-1:0] rsp_bpk_ff, rsp_bpk_in, rsp_lpk_ff, rsp_lpk_in;
   logic [RUN_W-1:0]      rsp_run_ff, rsp_run_in;

   logic             accept, store_ok, slot_free, emit;
   logic [AW-1:0]    wr_addr;
   logic [MAG_W-1:0] base_rd, live_rd;

   sbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sbc_ram #(.WIDTH(MAG_W), .DEPTH(BINS)) u_base_ram (
      .clock   (clock),
      .wr_en   (accept && store_ok),
      .wr_addr (wr_addr),
      .wr_data (req_base_mag),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (base_rd)
   );

   sbc_ram #(.WIDTH(MAG_W), .DEPTH(BINS)) u_live_ram (
      .clock   (clock),
      .wr_en   (accept && store_ok),
      .wr_addr (wr_addr),
      .wr_data (req_live_mag),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (live_rd)
   );

   sbc_judge #(.SUM_W(SUM_W), .FREQ_W(FREQ_W)) u_judge (
      .base_peak (fb_val_ff),
      .live_peak (fl_val_ff),
      .base_sum  (bsum_ff),
      .live_sum  (lsum_ff),
      .freq      (freq_ff),
      .run_in    (run_ff),
      .cfg       (cfg),
      .verdict   (verdict)
   );

   // take bins only while collecting
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign store_ok  = cnt_ff < CNTW'(BINS);
   assign wr_addr   = cnt_ff[AW-1:0];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == S_FINAL) && slot_free;
   assign rd_en     = (state_ff == S_BAND);

   // band bounds, clipped to bins 1 .. size-1
   always_comb begin
      pk_ext      = CW'(fb_idx_ff);
      size_ext    = CW'(size_ff);
      band_lo     = (pk_ext > CW'(BAND_HALF_WIDTH)) ? pk_ext - CW'(BAND_HALF_WIDTH)
                                                    : CW'(1);
      band_hi_raw = pk_ext + CW'(BAND_HALF_WIDTH);
      band_hi     = (band_hi_raw + CW'(1) > size_ext) ? size_ext - CW'(1) : band_hi_raw;
      band_empty  = band_lo > band_hi;
      peak_dist   = (fb_idx_ff > fl_idx_ff) ? fb_idx_ff - fl_idx_ff : fl_idx_ff - fb_idx_ff;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      bpk_val_in  = bpk_val_ff;
      bpk_idx_in  = bpk_idx_ff;
      lpk_val_in  = lpk_val_ff;
      lpk_idx_in  = lpk_idx_ff;
      fb_val_in   = fb_val_ff;
      fb_idx_in   = fb_idx_ff;
      fl_val_in   = fl_val_ff;
      fl_idx_in   = fl_idx_ff;
      size_in     = size_ff;
      rd_addr_in  = rd_addr_ff;
      band_end_in = band_end_ff;
      rd_pend_in  = 1'b0;
      bsum_in     = bsum_ff;
      lsum_in     = lsum_ff;
      freq_in     = freq_ff;
      run_in      = run_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_bpk_in    = rsp_bpk_ff;
      rsp_lpk_in    = rsp_lpk_ff;
      rsp_run_in    = rsp_run_ff;

      // accumulate the read issued last cycle
      if (rd_pend_ff) begin
         bsum_in = bsum_ff + SUM_W'(base_rd);
         lsum_in = lsum_ff + SUM_W'(live_rd);
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_clear_run) begin
                  run_in = '0;
               end
               if (store_ok) begin
                  if (cnt_ff != '0) begin
                     if (req_base_mag > bpk_val_ff) begin
                        bpk_val_in = req_base_mag;
                        bpk_idx_in = cnt_ff[AW-1:0];
                     end
                     if (req_live_mag > lpk_val_ff) begin
                        lpk_val_in = req_live_mag;
                        lpk_idx_in = cnt_ff[AW-1:0];
                     end
                  end
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_last_bin) begin
                  // freeze the frame, restart the trackers
                  fb_val_in  = bpk_val_in;
                  fb_idx_in  = bpk_idx_in;
                  fl_val_in  = lpk_val_in;
                  fl_idx_in  = lpk_idx_in;
                  size_in    = cnt_in;
                  cnt_in     = '0;
                  bpk_val_in = '0;
                  bpk_idx_in = AW'(1);
                  lpk_val_in = '0;
                  lpk_idx_in = AW'(1);
                  state_in   = S_START;
               end
            end
         end
         S_START: begin
            bsum_in     = '0;
            lsum_in     = '0;
            freq_in     = FREQ_W'(peak_dist) * FREQ_W'(cfg.bin_width);
            rd_addr_in  = band_lo[AW-1:0];
            band_end_in = band_hi[AW-1:0];
            state_in    = band_empty ? S_FINAL : S_BAND;
         end
         S_BAND: begin
            rd_pend_in = 1'b1;
            if (rd_addr_ff == band_end_ff) begin
               state_in = S_WAIT;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (emit) begin
               run_in        = verdict.run;
               rsp_valid_in  = 1'b1;
               rsp_status_in = verdict.status;
               rsp_bpk_in    = PEAK_OUT_W'(fb_idx_ff);
               rsp_lpk_in    = PEAK_OUT_W'(fl_idx_ff);
               rsp_run_in    = verdict.run;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         bpk_val_ff   <= '0;
         bpk_idx_ff   <= AW'(1);
         lpk_val_ff   <= '0;
         lpk_idx_ff   <= AW'(1);
         rd_pend_ff   <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bpk_val_ff   <= bpk_val_in;
         bpk_idx_ff   <= bpk_idx_in;
         lpk_val_ff   <= lpk_val_in;
         lpk_idx_ff   <= lpk_idx_in;
         rd_pend_ff   <= rd_pend_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fb_val_ff     <= fb_val_in;
      fb_idx_ff     <= fb_idx_in;
      fl_val_ff     <= fl_val_in;
      fl_idx_ff     <= fl_idx_in;
      size_ff       <= size_in;
      rd_addr_ff    <= rd_addr_in;
      band_end_ff   <= band_end_in;
      bsum_ff       <= bsum_in;
      lsum_ff       <= lsum_in;
      freq_ff       <= freq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bpk_ff    <= rsp_bpk_in;
      rsp_lpk_ff    <= rsp_lpk_in;
      rsp_run_ff    <= rsp_run_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_base_peak_bin = rsp_bpk_ff;
   assign rsp_live_peak_bin = rsp_lpk_ff;
   assign rsp_error_run     = rsp_run_ff;

   // a new verdict is loaded only out of the final state
   a_emit_from_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_FINAL))
      else $error("verdict loaded outside the final state");

   // an error verdict always comes with a nonzero run
   a_error_has_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_ERROR) |-> (rsp_run_ff != '0))
      else $error("error verdict with empty run");

   // band reads never pass the band end
   a_read_in_band: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BAND) |-> (rd_addr_ff <= band_end_ff))
      else $error("band read past its end");

   // the bin counter never runs past the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(BINS))
      else $error("bin count beyond store depth");

endmodule
